// ----- src/indexed_texture_upscaler_core_macros.svh -----
`ifndef INDEXED_TEXTURE_UPSCALER_CORE_MACROS_SVH
`define INDEXED_TEXTURE_UPSCALER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ITU_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itu check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ITU_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itu check failed");

`endif

// ----- src/itu_pkg.sv -----
`timescale 1ns / 1ps

package itu_pkg;

    localparam int DEF_MAX_SRC_SIDE = 64;

    localparam int DIM_W   = 7;
    localparam int PIX_W   = 8;
    localparam int SIDE_W  = 8;
    localparam int COL_W   = 8;
    localparam int STAT_W  = 2;
    localparam int SUPER_W = 24;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W  = 2 * DIM_W;

    localparam int SUPER_FIRST = 16;
    localparam int SUPER_END   = 22;
    localparam int PAL_SIZE    = 16;
    localparam int STD_SCALE   = 18;
    localparam int SWITCH_LO   = 9;
    localparam int SWITCH_HI   = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH     = 3'd0,
        CFG_SRC_HEIGHT    = 3'd1,
        CFG_PALETTE_MODE  = 3'd2,
        CFG_SWITCH_SCHEME = 3'd3,
        CFG_SUPER_MAP     = 3'd4
    } cfg_reg_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_INDEX = 2'd2
    } status_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic {
        PAL_EIGHT_BIT = 1'b0,
        PAL_STANDARD  = 1'b1
    } pal_mode_t;

    typedef struct packed {
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic              square;
        logic [2:0]        shift;
        logic [SIDE_W-1:0] side;
    } geom_t;

    typedef struct packed {
        op_t               op;
        logic              scaled;
        status_t           status;
        logic [SIDE_W-1:0] side;
    } rd_meta_t;

    typedef struct packed {
        logic [COL_W-1:0]  red;
        logic [COL_W-1:0]  green;
        logic [COL_W-1:0]  blue;
        logic [SIDE_W-1:0] side;
        status_t           status;
    } result_t;

    // 8-bit palette, packed as red, green, blue
    localparam logic [23:0] PAL8 [0:PAL_SIZE-1] = '{
        24'h000000, 24'h6D6D6D, 24'h919191, 24'h6D2400,
        24'h00FFFF, 24'h944A00, 24'h008000, 24'h00FF00,
        24'hFF0000, 24'hFFC400, 24'hDA916D, 24'hFFFF00,
        24'h535353, 24'hC4C4C4, 24'h0000FF, 24'hFFFFFF
    };

    // 4-bit standard palette, packed as red, green, blue nibbles
    localparam logic [11:0] PAL4 [0:PAL_SIZE-1] = '{
        12'h000, 12'h666, 12'h888, 12'h620,
        12'h0EE, 12'h840, 12'h070, 12'h0E0,
        12'hE00, 12'hEB0, 12'hC86, 12'hEE0,
        12'h444, 12'hBBB, 12'h00E, 12'hEEE
    };

    // Switch colour pairs, entry scheme*2 + (index is the upper switch index)
    localparam logic [11:0] SWITCH_PAIRS [0:15] = '{
        12'h700, 12'h500,
        12'hC90, 12'hC70,
        12'h009, 12'h007,
        12'h909, 12'h707,
        12'h530, 12'h750,
        12'hC90, 12'h050,
        12'hA90, 12'h750,
        12'hEB0, 12'hC86
    };

    function automatic logic [COL_W-1:0] scale_std(input logic [3:0] v);
        return COL_W'(v * STD_SCALE);
    endfunction

    function automatic logic [2:0] bit_len7(input logic [DIM_W-1:0] v);
        logic [2:0] n;
        n = 3'd0;
        for (int i = 0; i < DIM_W; i++) begin
            if (v[i]) begin
                n = 3'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// ----- src/indexed_texture_upscaler_core.sv -----
`timescale 1ns / 1ps

// Palette lookup with a nearest-neighbour scaler. Load beats write 8-bit colour
// indices into a single-port pixel store of MAX_SRC_SIDE x MAX_SRC_SIDE entries;
// read beats return the RGB colour of one pixel of the square output texture.
// Three register stages: the accept stage (source coordinate products), the
// store access stage (one read or write of the single port per beat), and the
// output register holding palette results. One beat per cycle is sustained
// while the output register is not stalled, and a stalled output register holds
// every stage. The store powers up undefined and gets no clearing pass, so read
// only pixels that were loaded. Configuration is always ready and must change
// only while no beat is in flight.
module indexed_texture_upscaler_core #(
    parameter int MAX_SRC_SIDE = itu_pkg::DEF_MAX_SRC_SIDE
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [itu_pkg::PIX_W-1:0]     pixel_value,
    input  logic [itu_pkg::DIM_W-1:0]     coord_x,
    input  logic [itu_pkg::DIM_W-1:0]     coord_y,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [itu_pkg::COL_W-1:0]     red,
    output logic [itu_pkg::COL_W-1:0]     green,
    output logic [itu_pkg::COL_W-1:0]     blue,
    output logic [itu_pkg::SIDE_W-1:0]    texture_side,
    output logic [itu_pkg::STAT_W-1:0]    status,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [itu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [itu_pkg::SUPER_W-1:0]   cfg_data
);

    localparam int IW    = $clog2(MAX_SRC_SIDE);
    localparam int DEPTH = MAX_SRC_SIDE * MAX_SRC_SIDE;
    localparam int AW    = $clog2(DEPTH);

    // Configuration registers
    logic [itu_pkg::DIM_W-1:0]   src_width_reg;
    logic [itu_pkg::DIM_W-1:0]   src_height_reg;
    itu_pkg::pal_mode_t          palette_mode_reg;
    logic [2:0]                  switch_scheme_reg;
    logic [itu_pkg::SUPER_W-1:0] super_map_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg     <= itu_pkg::DIM_W'(1);
            src_height_reg    <= itu_pkg::DIM_W'(1);
            palette_mode_reg  <= itu_pkg::PAL_EIGHT_BIT;
            switch_scheme_reg <= '0;
            super_map_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                itu_pkg::CFG_SRC_WIDTH:
                    src_width_reg <= cfg_data[itu_pkg::DIM_W-1:0];
                itu_pkg::CFG_SRC_HEIGHT:
                    src_height_reg <= cfg_data[itu_pkg::DIM_W-1:0];
                itu_pkg::CFG_PALETTE_MODE:
                    palette_mode_reg <= itu_pkg::pal_mode_t'(cfg_data[0]);
                itu_pkg::CFG_SWITCH_SCHEME:
                    switch_scheme_reg <= cfg_data[2:0];
                itu_pkg::CFG_SUPER_MAP:
                    super_map_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    itu_pkg::geom_t geom;

    itu_geom #(
        .MAX_SRC_SIDE (MAX_SRC_SIDE)
    ) u_geom (
        .src_width  (src_width_reg),
        .src_height (src_height_reg),
        .geom       (geom)
    );

    // Whole pipe advances unless a finished result is held
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // Accept stage
    itu_pkg::op_t                in_op;
    logic                        in_inside;
    logic                        in_scaled;
    logic [itu_pkg::PROD_W-1:0]  in_px;
    logic [itu_pkg::PROD_W-1:0]  in_py;

    assign in_op     = itu_pkg::op_t'(mode);
    assign in_scaled = (in_op == itu_pkg::OP_READ) && !geom.square;

    always_comb
    begin
        if (in_op == itu_pkg::OP_LOAD)
            in_inside = (coord_x < geom.w) && (coord_y < geom.h);
        else
            in_inside = ({1'b0, coord_x} < geom.side) && ({1'b0, coord_y} < geom.side);

        if (in_scaled)
        begin
            in_px = itu_pkg::PROD_W'(coord_x) * itu_pkg::PROD_W'(geom.w);
            in_py = itu_pkg::PROD_W'(coord_y) * itu_pkg::PROD_W'(geom.h);
        end
        else
        begin
            in_px = itu_pkg::PROD_W'(coord_x);
            in_py = itu_pkg::PROD_W'(coord_y);
        end
    end

    logic                        s1_valid_reg;
    itu_pkg::op_t                s1_op_reg;
    logic                        s1_scaled_reg;
    itu_pkg::status_t            s1_status_reg;
    logic [itu_pkg::SIDE_W-1:0]  s1_side_reg;
    logic [2:0]                  s1_shift_reg;
    logic [itu_pkg::PIX_W-1:0]   s1_pv_reg;
    logic [itu_pkg::PROD_W-1:0]  s1_px_reg;
    logic [itu_pkg::PROD_W-1:0]  s1_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            s1_op_reg     <= in_op;
            s1_scaled_reg <= in_scaled;
            s1_status_reg <= in_inside ? itu_pkg::ST_OK : itu_pkg::ST_RANGE;
            s1_side_reg   <= geom.side;
            s1_shift_reg  <= geom.shift;
            s1_pv_reg     <= pixel_value;
            s1_px_reg     <= in_px;
            s1_py_reg     <= in_py;
        end
    end

    // Store access stage: divide by the power-of-two side, form the address
    logic [itu_pkg::PROD_W-1:0] sx_full;
    logic [itu_pkg::PROD_W-1:0] sy_full;
    logic [AW-1:0]              ram_addr;
    logic                       ram_en;
    logic                       ram_we;
    logic [itu_pkg::PIX_W-1:0]  ram_rdata;

    assign sx_full  = s1_scaled_reg ? (s1_px_reg >> s1_shift_reg) : s1_px_reg;
    assign sy_full  = s1_scaled_reg ? (s1_py_reg >> s1_shift_reg) : s1_py_reg;
    assign ram_addr = AW'(sy_full[IW-1:0]) * AW'(MAX_SRC_SIDE) + AW'(sx_full[IW-1:0]);
    assign ram_en   = s1_valid_reg && adv && (s1_status_reg == itu_pkg::ST_OK);
    assign ram_we   = (s1_op_reg == itu_pkg::OP_LOAD);

    itu_ram #(
        .WIDTH (itu_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s1_pv_reg),
        .rdata (ram_rdata)
    );

    logic              s2_valid_reg;
    itu_pkg::rd_meta_t s2_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            s2_meta_reg.op     <= s1_op_reg;
            s2_meta_reg.scaled <= s1_scaled_reg;
            s2_meta_reg.status <= s1_status_reg;
            s2_meta_reg.side   <= s1_side_reg;
        end
    end

    // Palette stage into the output register
    itu_pkg::result_t res_next;
    itu_pkg::result_t res_reg;
    logic             out_valid_reg;

    itu_color u_color (
        .meta          (s2_meta_reg),
        .index         (ram_rdata),
        .palette_mode  (palette_mode_reg),
        .switch_scheme (switch_scheme_reg),
        .super_map     (super_map_reg),
        .res           (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg)
            res_reg <= res_next;
    end

    assign out_valid    = out_valid_reg;
    assign red          = res_reg.red;
    assign green        = res_reg.green;
    assign blue         = res_reg.blue;
    assign texture_side = res_reg.side;
    assign status       = res_reg.status;

endmodule

// ----- src/itu_ram.sv -----
`timescale 1ns / 1ps

module itu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// ----- src/itu_geom.sv -----
`timescale 1ns / 1ps

module itu_geom #(
    parameter int MAX_SRC_SIDE = itu_pkg::DEF_MAX_SRC_SIDE
) (
    input  logic [itu_pkg::DIM_W-1:0] src_width,
    input  logic [itu_pkg::DIM_W-1:0] src_height,
    output itu_pkg::geom_t            geom
);

    logic [itu_pkg::DIM_W-1:0] w;
    logic [itu_pkg::DIM_W-1:0] h;
    logic [itu_pkg::DIM_W-1:0] larger;
    logic [2:0]                len;

    // Clamp a side into 1 .. MAX_SRC_SIDE
    always_comb
    begin
        if (src_width == '0)
            w = itu_pkg::DIM_W'(1);
        else if (int'(src_width) > MAX_SRC_SIDE)
            w = itu_pkg::DIM_W'(MAX_SRC_SIDE);
        else
            w = src_width;

        if (src_height == '0)
            h = itu_pkg::DIM_W'(1);
        else if (int'(src_height) > MAX_SRC_SIDE)
            h = itu_pkg::DIM_W'(MAX_SRC_SIDE);
        else
            h = src_height;
    end

    assign larger = (w > h) ? w : h;
    assign len    = itu_pkg::bit_len7(larger);

    always_comb
    begin
        geom.w      = w;
        geom.h      = h;
        geom.square = (w == h);
        geom.shift  = len;
        geom.side   = (w == h) ? {1'b0, w} : (itu_pkg::SIDE_W'(1) << len);
    end

endmodule

// ----- src/itu_color.sv -----
`timescale 1ns / 1ps

module itu_color (
    input  itu_pkg::rd_meta_t           meta,
    input  logic [itu_pkg::PIX_W-1:0]   index,
    input  itu_pkg::pal_mode_t          palette_mode,
    input  logic [2:0]                  switch_scheme,
    input  logic [itu_pkg::SUPER_W-1:0] super_map,
    output itu_pkg::result_t            res
);

    logic [itu_pkg::PIX_W-1:0] idx;
    logic [2:0]                sel;
    logic [23:0]               rgb8;
    logic [11:0]               rgb4;
    logic [3:0]                sw_addr;

    // Remap superpalette indices on a scaled source only
    always_comb
    begin
        sel = 3'(index - itu_pkg::PIX_W'(itu_pkg::SUPER_FIRST));
        idx = index;
        if (meta.scaled && index >= itu_pkg::PIX_W'(itu_pkg::SUPER_FIRST)
            && index < itu_pkg::PIX_W'(itu_pkg::SUPER_END))
        begin
            idx = {4'b0000, super_map[4*sel +: 4]};
        end
    end

    assign sw_addr = {switch_scheme, idx == itu_pkg::PIX_W'(itu_pkg::SWITCH_HI)};
    assign rgb8    = itu_pkg::PAL8[idx[3:0]];
    assign rgb4    = (idx == itu_pkg::PIX_W'(itu_pkg::SWITCH_LO)
                      || idx == itu_pkg::PIX_W'(itu_pkg::SWITCH_HI))
                     ? itu_pkg::SWITCH_PAIRS[sw_addr] : itu_pkg::PAL4[idx[3:0]];

    always_comb
    begin
        res.red    = '0;
        res.green  = '0;
        res.blue   = '0;
        res.side   = meta.side;
        res.status = meta.status;
        if (meta.status == itu_pkg::ST_OK && meta.op == itu_pkg::OP_READ)
        begin
            if (idx >= itu_pkg::PIX_W'(itu_pkg::PAL_SIZE))
            begin
                res.status = itu_pkg::ST_INDEX;
            end
            else if (!meta.scaled || palette_mode == itu_pkg::PAL_EIGHT_BIT)
            begin
                res.red   = rgb8[23:16];
                res.green = rgb8[15:8];
                res.blue  = rgb8[7:0];
            end
            else
            begin
                res.red   = itu_pkg::scale_std(rgb4[11:8]);
                res.green = itu_pkg::scale_std(rgb4[7:4]);
                res.blue  = itu_pkg::scale_std(rgb4[3:0]);
            end
        end
    end

endmodule

// ----- src/itu_checker.sv -----
`timescale 1ns / 1ps

`include "indexed_texture_upscaler_core_macros.svh"

module itu_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [itu_pkg::COL_W-1:0]  red,
    input logic [itu_pkg::COL_W-1:0]  green,
    input logic [itu_pkg::COL_W-1:0]  blue,
    input logic [itu_pkg::SIDE_W-1:0] texture_side,
    input logic [itu_pkg::STAT_W-1:0] status
);

    logic [3*itu_pkg::COL_W+itu_pkg::SIDE_W+itu_pkg::STAT_W-1:0] res_bits;

    assign res_bits = {red, green, blue, texture_side, status};

    // An empty output register never holds back the input
    `ITU_ASSERT_IMP(a_empty_accepts, !out_valid, !in_stall)

    // Hold a stalled result beat
    `ITU_ASSERT_NXT(a_result_holds, out_valid && out_stall, out_valid && $stable(res_bits))

    // Any flagged beat carries black
    `ITU_ASSERT_IMP(a_flag_black, out_valid && status != itu_pkg::ST_OK, {red, green, blue} == '0)

    // The texture always has at least one pixel
    `ITU_ASSERT_IMP(a_side_nonzero, out_valid, texture_side != '0)

endmodule

bind indexed_texture_upscaler_core itu_checker u_checker (.*);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import itu_pkg::*;

    localparam int SIDE_MAX     = 64;
    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT  = 400000;

    // source sizes at and beyond the clamping points
    localparam int EDGE_DIMS [7] = '{0, 1, 2, 63, 64, 65, 127};

    // red, green, blue per colour index
    localparam logic [7:0] FULL_RGB [16][3] = '{
        '{0, 0, 0},     '{109, 109, 109}, '{145, 145, 145}, '{109, 36, 0},
        '{0, 255, 255}, '{148, 74, 0},    '{0, 128, 0},     '{0, 255, 0},
        '{255, 0, 0},   '{255, 196, 0},   '{218, 145, 109}, '{255, 255, 0},
        '{83, 83, 83},  '{196, 196, 196}, '{0, 0, 255},     '{255, 255, 255}
    };

    localparam logic [3:0] NIBBLE_RGB [16][3] = '{
        '{0, 0, 0},   '{6, 6, 6},    '{8, 8, 8},    '{6, 2, 0},
        '{0, 14, 14}, '{8, 4, 0},    '{0, 7, 0},    '{0, 14, 0},
        '{14, 0, 0},  '{14, 11, 0},  '{12, 8, 6},   '{14, 14, 0},
        '{4, 4, 4},   '{11, 11, 11}, '{0, 0, 14},   '{14, 14, 14}
    };

    localparam logic [3:0] SWITCH_RGB [8][2][3] = '{
        '{'{7, 0, 0},   '{5, 0, 0}},
        '{'{12, 9, 0},  '{12, 7, 0}},
        '{'{0, 0, 9},   '{0, 0, 7}},
        '{'{9, 0, 9},   '{7, 0, 7}},
        '{'{5, 3, 0},   '{7, 5, 0}},
        '{'{12, 9, 0},  '{0, 5, 0}},
        '{'{10, 9, 0},  '{7, 5, 0}},
        '{'{14, 11, 0}, '{12, 8, 6}}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 mode = 1'b0;
    logic [PIX_W-1:0]     pixel_value = '0;
    logic [DIM_W-1:0]     coord_x = '0;
    logic [DIM_W-1:0]     coord_y = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [COL_W-1:0]     red;
    logic [COL_W-1:0]     green;
    logic [COL_W-1:0]     blue;
    logic [SIDE_W-1:0]    texture_side;
    logic [STAT_W-1:0]    status;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SUPER_W-1:0]   cfg_data = '0;

    // local copy of the source image and the registers
    logic [PIX_W-1:0]   src_pixels [SIDE_MAX*SIDE_MAX];
    bit                 pixel_loaded [SIDE_MAX*SIDE_MAX];
    logic [DIM_W-1:0]   reg_width = 7'd1;
    logic [DIM_W-1:0]   reg_height = 7'd1;
    logic               reg_palette = 1'b0;
    logic [2:0]         reg_switch = 3'd0;
    logic [SUPER_W-1:0] reg_super = '0;

    result_t texels_due [$];
    result_t oldest_texel;
    int      mismatches = 0;
    int      cycles = 0;
    bit      loader_pauses = 1'b1;
    bit      sink_pauses = 1'b1;

    indexed_texture_upscaler_core #(
        .MAX_SRC_SIDE(SIDE_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .pixel_value(pixel_value),
        .coord_x(coord_x),
        .coord_y(coord_y),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .red(red),
        .green(green),
        .blue(blue),
        .texture_side(texture_side),
        .status(status),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int clamped(logic [DIM_W-1:0] v);
        if (v == 0)
        begin
            return 1;
        end
        if (v > SIDE_MAX)
        begin
            return SIDE_MAX;
        end
        return int'(v);
    endfunction

    function automatic int texture_edge();
        int w;
        int h;
        w = clamped(reg_width);
        h = clamped(reg_height);
        if (w == h)
        begin
            return w;
        end
        return 1 << $clog2((w > h ? w : h) + 1);
    endfunction

    // store entry behind an output pixel, -1 when outside the texture
    function automatic int texel_source(int x, int y);
        int w;
        int h;
        int side;
        w = clamped(reg_width);
        h = clamped(reg_height);
        side = texture_edge();
        if (x >= side || y >= side)
        begin
            return -1;
        end
        if (w == h)
        begin
            return y * SIDE_MAX + x;
        end
        return (y * h / side) * SIDE_MAX + (x * w / side);
    endfunction

    function automatic result_t predict_texel(op_t op, logic [PIX_W-1:0] val, int x, int y);
        result_t res;
        int      w;
        int      h;
        int      src;
        int      c;
        w = clamped(reg_width);
        h = clamped(reg_height);
        res = '0;
        res.side = SIDE_W'(texture_edge());
        if (op == OP_LOAD)
        begin
            if (x < w && y < h)
            begin
                src_pixels[y * SIDE_MAX + x] = val;
                pixel_loaded[y * SIDE_MAX + x] = 1'b1;
            end
            else
            begin
                res.status = ST_RANGE;
            end
            return res;
        end
        src = texel_source(x, y);
        if (src < 0)
        begin
            res.status = ST_RANGE;
            return res;
        end
        c = pixel_loaded[src] ? int'(src_pixels[src]) : 0;
        // superpalette applies to scaled sources only
        if (w != h && c >= SUPER_FIRST && c < SUPER_END)
        begin
            c = (reg_super >> (4 * (c - SUPER_FIRST))) & 15;
        end
        if (c >= PAL_SIZE)
        begin
            res.status = ST_INDEX;
        end
        else if (w == h || reg_palette == PAL_EIGHT_BIT)
        begin
            res.red   = FULL_RGB[c][0];
            res.green = FULL_RGB[c][1];
            res.blue  = FULL_RGB[c][2];
        end
        else if (c == SWITCH_LO || c == SWITCH_HI)
        begin
            res.red   = COL_W'(SWITCH_RGB[reg_switch][c - SWITCH_LO][0] * STD_SCALE);
            res.green = COL_W'(SWITCH_RGB[reg_switch][c - SWITCH_LO][1] * STD_SCALE);
            res.blue  = COL_W'(SWITCH_RGB[reg_switch][c - SWITCH_LO][2] * STD_SCALE);
        end
        else
        begin
            res.red   = COL_W'(NIBBLE_RGB[c][0] * STD_SCALE);
            res.green = COL_W'(NIBBLE_RGB[c][1] * STD_SCALE);
            res.blue  = COL_W'(NIBBLE_RGB[c][2] * STD_SCALE);
        end
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] random_index();
        case ($urandom_range(0, 3))
            0: return PIX_W'($urandom_range(0, PAL_SIZE - 1));
            1: return PIX_W'($urandom_range(SUPER_FIRST, SUPER_END - 1));
            2: return PIX_W'($urandom_range(SWITCH_LO, SWITCH_HI));
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic send_beat(op_t op, logic [PIX_W-1:0] val, int x, int y);
        int gap;
        gap = loader_pauses ? $urandom_range(0, 19) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= op;
        pixel_value <= val;
        coord_x     <= DIM_W'(x);
        coord_y     <= DIM_W'(y);
        do @(posedge clk); while (in_stall);
        texels_due.push_back(predict_texel(op, val, x, y));
    endtask

    // read a pixel whose source entry has been loaded, or one outside the texture
    task automatic send_read(bit anywhere);
        int x;
        int y;
        int src;
        int tries;
        x = 0;
        y = 0;
        src = 0;
        for (tries = 0; tries < 40; tries++)
        begin
            x = anywhere ? $urandom_range(0, 127) : $urandom_range(0, texture_edge() - 1);
            y = anywhere ? $urandom_range(0, 127) : $urandom_range(0, texture_edge() - 1);
            src = texel_source(x, y);
            if (src < 0 || pixel_loaded[src])
            begin
                break;
            end
        end
        if (src >= 0 && !pixel_loaded[src])
        begin
            x = 0;
            y = 0;
        end
        send_beat(OP_READ, PIX_W'($urandom), x, y);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (texels_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [SUPER_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_SRC_WIDTH:     reg_width = data[DIM_W-1:0];
            CFG_SRC_HEIGHT:    reg_height = data[DIM_W-1:0];
            CFG_PALETTE_MODE:  reg_palette = data[0];
            CFG_SWITCH_SCHEME: reg_switch = data[2:0];
            CFG_SUPER_MAP:     reg_super = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [SUPER_W-1:0] w, logic [SUPER_W-1:0] h,
                             logic [SUPER_W-1:0] pal, logic [SUPER_W-1:0] scheme,
                             logic [SUPER_W-1:0] remap);
        drain();
        write_reg(CFG_SRC_WIDTH, w);
        write_reg(CFG_SRC_HEIGHT, h);
        write_reg(CFG_PALETTE_MODE, pal);
        write_reg(CFG_SWITCH_SCHEME, scheme);
        write_reg(CFG_SUPER_MAP, remap);
        repeat (3) @(posedge clk);
    endtask

    task automatic test_square_source();
        // one-pixel source straight after reset
        send_beat(OP_LOAD, 8'd5, 0, 0);
        send_beat(OP_READ, 8'hFF, 0, 0);
        send_beat(OP_READ, 8'h00, 1, 0);
        send_beat(OP_LOAD, 8'd3, 1, 1);
        // largest square: palette mode and remap must have no effect
        configure(64, 64, SUPER_W'(PAL_STANDARD), 7, 24'hFFFFFF);
        send_beat(OP_LOAD, 8'd15, 63, 63);
        send_beat(OP_LOAD, 8'd255, 0, 0);
        send_beat(OP_LOAD, 8'd16, 63, 0);
        send_beat(OP_READ, 8'h00, 63, 63);
        send_beat(OP_READ, 8'h00, 0, 0);
        send_beat(OP_READ, 8'h00, 63, 0);
        send_beat(OP_READ, 8'h00, 64, 0);
        send_beat(OP_LOAD, 8'd1, 127, 127);
    endtask

    task automatic test_scaled_source();
        // 3 x 5 source scales to an 8 x 8 texture
        configure(3, 5, SUPER_W'(PAL_EIGHT_BIT), 7, 24'h0A9F10);
        send_beat(OP_LOAD, 8'd9, 0, 0);
        send_beat(OP_LOAD, 8'd18, 2, 4);
        send_beat(OP_LOAD, 8'd22, 1, 2);
        send_beat(OP_READ, 8'h00, 0, 0);
        send_beat(OP_READ, 8'h00, 7, 7);
        send_beat(OP_READ, 8'h00, 3, 4);
        send_beat(OP_READ, 8'h00, 8, 0);
        configure(3, 5, SUPER_W'(PAL_STANDARD), 7, 24'h0A9F10);
        send_beat(OP_READ, 8'h00, 0, 0);
        send_beat(OP_READ, 8'h00, 7, 7);
        configure(3, 5, SUPER_W'(PAL_STANDARD), 3, 24'h0A9F10);
        send_beat(OP_LOAD, 8'd10, 2, 4);
        send_beat(OP_READ, 8'h00, 7, 7);
    endtask

    task automatic test_random_phases();
        int               sent;
        int               pick;
        int               w;
        int               h;
        int               burst;
        logic [SUPER_W-1:0] wr;
        logic [SUPER_W-1:0] hr;
        logic [SUPER_W-1:0] remap;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
            begin
                wr = SUPER_W'($urandom_range(1, 8));
                hr = SUPER_W'($urandom_range(1, 8));
            end
            else if (pick < 17)
            begin
                wr = SUPER_W'($urandom_range(1, SIDE_MAX));
                hr = SUPER_W'($urandom_range(1, SIDE_MAX));
            end
            else
            begin
                wr = SUPER_W'(EDGE_DIMS[$urandom_range(0, 6)]);
                hr = SUPER_W'(EDGE_DIMS[$urandom_range(0, 6)]);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                hr = wr;
            end
            // junk above the register width must be dropped
            if ($urandom_range(0, 3) == 0)
            begin
                wr[SUPER_W-1:DIM_W] = (SUPER_W-DIM_W)'($urandom);
                hr[SUPER_W-1:DIM_W] = (SUPER_W-DIM_W)'($urandom);
            end
            case ($urandom_range(0, 9))
                0: remap = '0;
                1: remap = '1;
                default: remap = SUPER_W'($urandom);
            endcase
            configure(wr, hr, SUPER_W'($urandom), SUPER_W'($urandom), remap);
            loader_pauses = $urandom_range(0, 3) != 0;
            sink_pauses = $urandom_range(0, 3) != 0;
            w = clamped(reg_width);
            h = clamped(reg_height);
            // fill the source first; large images only in part, origin always
            if (w * h <= 64)
            begin
                for (int y = 0; y < h; y++)
                begin
                    for (int x = 0; x < w; x++)
                    begin
                        send_beat(OP_LOAD, random_index(), x, y);
                    end
                end
                sent += w * h;
            end
            else
            begin
                send_beat(OP_LOAD, random_index(), 0, 0);
                repeat (24)
                begin
                    send_beat(OP_LOAD, random_index(), $urandom_range(0, w - 1),
                              $urandom_range(0, h - 1));
                end
                sent += 25;
            end
            burst = $urandom_range(20, 60);
            repeat (burst)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    send_read(1'b0);
                end
                else if (pick == 7)
                begin
                    send_read(1'b1);
                end
                else if (pick == 8)
                begin
                    send_beat(OP_LOAD, random_index(), $urandom_range(0, w - 1),
                              $urandom_range(0, h - 1));
                end
                else
                begin
                    send_beat(OP_LOAD, PIX_W'($urandom), $urandom_range(0, 127),
                              $urandom_range(0, 127));
                end
            end
            sent += burst;
        end
    endtask

    initial
    begin : result_backpressure
        int hold;
        forever
        begin
            hold = sink_pauses ? $urandom_range(0, 19) : 0;
            repeat (hold)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (texels_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result beat with nothing pending: r=%0d g=%0d b=%0d side=%0d st=%0d",
                             red, green, blue, texture_side, status);
                end
            end
            else
            begin
                oldest_texel = texels_due.pop_front();
                if (red !== oldest_texel.red || green !== oldest_texel.green ||
                    blue !== oldest_texel.blue || texture_side !== oldest_texel.side ||
                    status !== oldest_texel.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: want r=%0d g=%0d b=%0d side=%0d st=%0d",
                                 oldest_texel.red, oldest_texel.green, oldest_texel.blue,
                                 oldest_texel.side, oldest_texel.status);
                        $display("          got  r=%0d g=%0d b=%0d side=%0d st=%0d",
                                 red, green, blue, texture_side, status);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        test_square_source();
        test_scaled_source();
        test_random_phases();
        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
